>>> sv/assert_macros.svh
// Assertion macros for the clip pipeline files.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Implication checked on every clock edge outside reset.
`define ASSERT_IMPL(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
// Property checked on every clock edge, reset included.
`define ASSERT_ALWAYS(label, clk, prop, msg) \
  label: assert property (@(posedge clk) (prop)) else $error(msg);
`endif

>>> sv/shpc_pkg.sv
// ---------------------------------------------------------------------------
// Segment clip package
// Shared coordinate width for the half-plane clip pipeline.
// ---------------------------------------------------------------------------
package shpc_pkg;
  localparam int CoordWidthDef = 16;
endpackage

>>> sv/shpc_div.sv
// ---------------------------------------------------------------------------
// Pipelined divider
// Restoring divider that retires one quotient bit per stage, truncating
// toward zero and saturating to the signed coordinate range.
// ---------------------------------------------------------------------------
module shpc_div #(
  parameter int NW = 80,
  parameter int DW = 34,
  parameter int QW = 16,
  parameter int TW = 1
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 en_i,
  input  logic                 valid_i,
  input  logic signed [NW-1:0] num_i,
  input  logic signed [DW-1:0] den_i,
  input  logic [TW-1:0]        tag_i,
  output logic                 valid_o,
  output logic [QW-1:0]        quot_o,
  output logic [TW-1:0]        tag_o
);
  // The magnitude quotient must fit QW bits plus one to detect overflow.
  localparam int NS = QW + 1;

  logic          v_q   [NS+1];
  logic [NW-1:0] rem_q [NS+1];
  logic [DW-1:0] d_q   [NS+1];
  logic [NS-1:0] qb_q  [NS+1];
  logic          ovf_q [NS+1];
  logic          neg_q [NS+1];
  logic          z_q   [NS+1];
  logic [TW-1:0] tag_q [NS+1];

  logic [NW-1:0] n_abs;
  logic [DW-1:0] d_abs;
  logic [NW:0]   hi_cmp;

  // Stage zero takes magnitudes and flags quotients too large for the range.
  always_comb begin
    n_abs  = num_i[NW-1] ? NW'(-num_i) : NW'(num_i);
    d_abs  = den_i[DW-1] ? DW'(-den_i) : DW'(den_i);
    hi_cmp = {1'b0, n_abs} >> NS;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i <= NS; i++) v_q[i] <= 1'b0;
    end else if (en_i) begin
      v_q[0] <= valid_i;
      for (int i = 1; i <= NS; i++) v_q[i] <= v_q[i-1];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rem_q[0] <= n_abs;
      d_q[0]   <= d_abs;
      qb_q[0]  <= '0;
      ovf_q[0] <= (NW'(hi_cmp) >= NW'(d_abs));
      neg_q[0] <= num_i[NW-1] ^ den_i[DW-1];
      z_q[0]   <= (den_i == '0);
      tag_q[0] <= tag_i;
      for (int i = 1; i <= NS; i++) begin
        d_q[i]   <= d_q[i-1];
        neg_q[i] <= neg_q[i-1];
        z_q[i]   <= z_q[i-1];
        tag_q[i] <= tag_q[i-1];
        ovf_q[i] <= ovf_q[i-1];
        if ((rem_q[i-1] >> (NS - i)) >= NW'(d_q[i-1])) begin
          rem_q[i] <= rem_q[i-1] - (NW'(d_q[i-1]) << (NS - i));
          qb_q[i]  <= qb_q[i-1] | (NS'(1) << (NS - i));
        end else begin
          rem_q[i] <= rem_q[i-1];
          qb_q[i]  <= qb_q[i-1];
        end
      end
    end
  end

  // Saturate, restore the sign; a zero divisor gives zero.
  logic [NS-1:0] lim;
  logic [NS-1:0] qm;
  always_comb begin
    lim = (NS'(1) << (QW - 1)) - (neg_q[NS] ? NS'(0) : NS'(1));
    qm  = (ovf_q[NS] || qb_q[NS] > lim) ? lim : qb_q[NS];
    quot_o = z_q[NS] ? '0 : (neg_q[NS] ? QW'(-qm) : QW'(qm));
  end
  assign valid_o = v_q[NS];
  assign tag_o   = tag_q[NS];
endmodule

>>> sv/shpc_front.sv
// ---------------------------------------------------------------------------
// Clip front end
// Four stages: differences, products, orientation tests, then numerators.
// ---------------------------------------------------------------------------
module shpc_front #(
  parameter int CW = 16
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 en_i,
  input  logic                 valid_i,
  input  logic signed [CW-1:0] x1_i, y1_i, x2_i, y2_i, x3_i, y3_i, x4_i, y4_i,
  output logic                 valid_o,
  output logic                 vis_o,
  output logic                 out1_o,
  output logic                 rep_o,
  output logic signed [4*CW+4:0] nx_o,
  output logic signed [4*CW+4:0] ny_o,
  output logic signed [2*CW+1:0] den_o,
  output logic signed [CW-1:0] x1_o, y1_o, x2_o, y2_o
);
  localparam int DF = CW + 1;
  localparam int PW = 2 * CW + 2;
  localparam int NW = 4 * CW + 5;

  logic [3:0] v_q;
  logic signed [CW-1:0] p_q [4][8];
  logic signed [DF-1:0] a_q, b_q, c1x_q, c1y_q, c2x_q, c2y_q;
  logic signed [DF-1:0] dx12_q, dy12_q, dx34_q, dy34_q;
  logic signed [PW-1:0] o1a_q, o1b_q, o2a_q, o2b_q, dena_q, denb_q;
  logic signed [PW-1:0] c1a_q, c1b_q, c2a_q, c2b_q;
  logic signed [DF-1:0] dx12b_q, dy12b_q, dx34b_q, dy34b_q;
  logic                 o1_q, o2_q;
  logic signed [PW-1:0] den_q, c1_q, c2_q;
  logic signed [DF-1:0] dx12c_q, dy12c_q, dx34c_q, dy34c_q;
  logic                 o1d_q, o2d_q;
  logic signed [NW-1:0] nx_q, ny_q;
  logic signed [PW-1:0] dend_q;
  logic signed [PW-1:0] o1, o2, dd, c1, c2;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) v_q <= '0;
    else if (en_i) v_q <= {v_q[2:0], valid_i};
  end

  always_comb begin
    o1 = o1a_q - o1b_q;
    o2 = o2a_q - o2b_q;
    dd = dena_q - denb_q;
    c1 = c1a_q - c1b_q;
    c2 = c2a_q - c2b_q;
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      // Stage one: coordinate differences.
      p_q[0] <= '{x1_i, y1_i, x2_i, y2_i, x3_i, y3_i, x4_i, y4_i};
      a_q    <= DF'(x4_i) - DF'(x3_i);
      b_q    <= DF'(y4_i) - DF'(y3_i);
      c1x_q  <= DF'(x1_i) - DF'(x4_i);
      c1y_q  <= DF'(y1_i) - DF'(y4_i);
      c2x_q  <= DF'(x2_i) - DF'(x4_i);
      c2y_q  <= DF'(y2_i) - DF'(y4_i);
      dx12_q <= DF'(x1_i) - DF'(x2_i);
      dy12_q <= DF'(y1_i) - DF'(y2_i);
      dx34_q <= DF'(x3_i) - DF'(x4_i);
      dy34_q <= DF'(y3_i) - DF'(y4_i);
      // Stage two: all products.
      p_q[1] <= p_q[0];
      o1a_q  <= PW'(a_q * c1y_q);
      o1b_q  <= PW'(c1x_q * b_q);
      o2a_q  <= PW'(a_q * c2y_q);
      o2b_q  <= PW'(c2x_q * b_q);
      dena_q <= PW'(dx12_q * dy34_q);
      denb_q <= PW'(dy12_q * dx34_q);
      c1a_q  <= PW'(p_q[0][0] * p_q[0][3]);
      c1b_q  <= PW'(p_q[0][2] * p_q[0][1]);
      c2a_q  <= PW'(p_q[0][4] * p_q[0][7]);
      c2b_q  <= PW'(p_q[0][6] * p_q[0][5]);
      dx12b_q <= dx12_q; dy12b_q <= dy12_q; dx34b_q <= dx34_q; dy34b_q <= dy34_q;
      // Stage three: orientation signs and cross terms.
      p_q[2]  <= p_q[1];
      o1_q    <= (o1 > 0);
      o2_q    <= (o2 > 0);
      den_q   <= dd;
      c1_q    <= c1;
      c2_q    <= c2;
      dx12c_q <= dx12b_q; dy12c_q <= dy12b_q; dx34c_q <= dx34b_q; dy34c_q <= dy34b_q;
      // Stage four: numerators, products of a 34-bit and a 17-bit term.
      p_q[3]  <= p_q[2];
      o1d_q   <= o1_q;
      o2d_q   <= o2_q;
      dend_q  <= den_q;
      nx_q    <= NW'(c1_q * dx34c_q) - NW'(dx12c_q * c2_q);
      ny_q    <= NW'(c1_q * dy34c_q) - NW'(dy12c_q * c2_q);
    end
  end

  assign nx_o   = nx_q;
  assign ny_o   = ny_q;
  assign den_o  = dend_q;
  assign valid_o = v_q[3];
  assign vis_o  = !(o1d_q && o2d_q);
  assign out1_o = o1d_q;
  assign rep_o  = o1d_q ^ o2d_q;
  assign x1_o = p_q[3][0];
  assign y1_o = p_q[3][1];
  assign x2_o = p_q[3][2];
  assign y2_o = p_q[3][3];
endmodule

>>> sv/segment_half_plane_clip.sv
// Pipeline: 4 front stages, then COORD_WIDTH+2 divider stages, then one output
// register.
// Throughput: one beat per cycle; the whole pipe advances when the output
// register is free or being taken, so a stall holds every stage in place.
// Reset clears all valid bits; payload registers are not reset.
// ---------------------------------------------------------------------------
// Segment half-plane clip
// Clips a segment against a directed line, replacing the outside endpoint or rejecting a segment wholly outside.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"
module segment_half_plane_clip #(
  parameter int COORD_WIDTH = shpc_pkg::CoordWidthDef
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic signed [COORD_WIDTH-1:0] seg_start_x_i,
  input  logic signed [COORD_WIDTH-1:0] seg_start_y_i,
  input  logic signed [COORD_WIDTH-1:0] seg_end_x_i,
  input  logic signed [COORD_WIDTH-1:0] seg_end_y_i,
  input  logic signed [COORD_WIDTH-1:0] clip_from_x_i,
  input  logic signed [COORD_WIDTH-1:0] clip_from_y_i,
  input  logic signed [COORD_WIDTH-1:0] clip_to_x_i,
  input  logic signed [COORD_WIDTH-1:0] clip_to_y_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic                          visible_o,
  output logic signed [COORD_WIDTH-1:0] out_start_x_o,
  output logic signed [COORD_WIDTH-1:0] out_start_y_o,
  output logic signed [COORD_WIDTH-1:0] out_end_x_o,
  output logic signed [COORD_WIDTH-1:0] out_end_y_o
);
  localparam int CW = COORD_WIDTH;
  localparam int NW = 4 * CW + 5;
  localparam int DW = 2 * CW + 2;
  localparam int TW = 3 + 4 * CW;

  typedef struct packed {
    logic          vis;
    logic          out1;
    logic          rep;
    logic [CW-1:0] x1, y1, x2, y2;
  } tag_t;

  logic en;
  logic fv, dvx, dvy;
  logic f_vis, f_out1, f_rep;
  logic signed [NW-1:0] nx, ny;
  logic signed [DW-1:0] den;
  logic signed [CW-1:0] x1, y1, x2, y2;
  logic [CW-1:0] qx, qy;
  tag_t tin, tx, ty;
  logic out_valid_q;
  logic vis_q;
  logic [CW-1:0] sx_q, sy_q, ex_q, ey_q;

  // The pipe moves whenever the output register can take a beat.
  assign en = !out_valid_q || out_ready_i;
  assign in_ready_o = en;

  shpc_front #(.CW(CW)) u_front (
    .clk_i, .rst_ni, .en_i(en), .valid_i(in_valid_i),
    .x1_i(seg_start_x_i), .y1_i(seg_start_y_i), .x2_i(seg_end_x_i), .y2_i(seg_end_y_i),
    .x3_i(clip_from_x_i), .y3_i(clip_from_y_i), .x4_i(clip_to_x_i), .y4_i(clip_to_y_i),
    .valid_o(fv), .vis_o(f_vis), .out1_o(f_out1), .rep_o(f_rep),
    .nx_o(nx), .ny_o(ny), .den_o(den),
    .x1_o(x1), .y1_o(y1), .x2_o(x2), .y2_o(y2)
  );

  assign tin = '{vis: f_vis, out1: f_out1, rep: f_rep, x1: x1, y1: y1, x2: x2, y2: y2};

  shpc_div #(.NW(NW), .DW(DW), .QW(CW), .TW(TW)) u_div_x (
    .clk_i, .rst_ni, .en_i(en), .valid_i(fv), .num_i(nx), .den_i(den),
    .tag_i(tin), .valid_o(dvx), .quot_o(qx), .tag_o(tx)
  );

  shpc_div #(.NW(NW), .DW(DW), .QW(CW), .TW(TW)) u_div_y (
    .clk_i, .rst_ni, .en_i(en), .valid_i(fv), .num_i(ny), .den_i(den),
    .tag_i(tin), .valid_o(dvy), .quot_o(qy), .tag_o(ty)
  );

  // Output register: pick the replaced endpoint.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) out_valid_q <= 1'b0;
    else if (en) out_valid_q <= dvx;
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      vis_q <= tx.vis;
      sx_q  <= (tx.rep && tx.out1) ? qx : tx.x1;
      sy_q  <= (tx.rep && tx.out1) ? qy : tx.y1;
      ex_q  <= (tx.rep && !tx.out1) ? qx : tx.x2;
      ey_q  <= (tx.rep && !tx.out1) ? qy : tx.y2;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign visible_o     = vis_q;
  assign out_start_x_o = sx_q;
  assign out_start_y_o = sy_q;
  assign out_end_x_o   = ex_q;
  assign out_end_y_o   = ey_q;

  logic unused;
  assign unused = ^ty;

  `ASSERT_IMPL(a_div_lockstep, clk_i, rst_ni, dvx == dvy, "dividers out of step")
  `ASSERT_IMPL(a_stall_hold, clk_i, rst_ni, out_valid_q && !out_ready_i |=> out_valid_q && $stable(sx_q), "stalled beat changed")
  `ASSERT_IMPL(a_reject_keeps, clk_i, rst_ni, out_valid_q && !vis_q |-> 1'b1 && !$isunknown(vis_q), "bad visible")
endmodule

>>> verif/tb_segment_half_plane_clip.sv
// ---------------------------------------------------------------------------
// Segment half-plane clip testbench
// Drives segment and clip-line beats with random gaps and output stalls,
// predicts each clipped segment exactly and compares it field by field.
// ---------------------------------------------------------------------------
module tb_segment_half_plane_clip;
  localparam int CW = shpc_pkg::CoordWidthDef;
  localparam int PipeLatency = CW + 7;

  typedef logic signed [CW-1:0] coord_t;
  typedef struct packed {
    logic   visible;
    coord_t sx, sy, ex, ey;
  } clip_result_t;

  // Exact signed quotient, truncated toward zero and clamped to the coordinate range.
  function automatic coord_t quotient_sat(logic signed [127:0] num, logic signed [127:0] den);
    logic signed [127:0] q;
    logic signed [127:0] hi_lim;
    logic signed [127:0] lo_lim;
    hi_lim = (128'sd1 <<< (CW - 1)) - 1;
    lo_lim = -(128'sd1 <<< (CW - 1));
    q = num / den;
    if (q > hi_lim) q = hi_lim;
    if (q < lo_lim) q = lo_lim;
    return q[CW-1:0];
  endfunction

  // Orientation of point p against the directed line a->b; positive means outside.
  function automatic logic is_outside(coord_t ax, coord_t ay, coord_t bx, coord_t by,
                                      coord_t px, coord_t py);
    logic signed [127:0] o;
    o = (128'(bx) - 128'(ax)) * (128'(py) - 128'(by))
      - (128'(px) - 128'(bx)) * (128'(by) - 128'(ay));
    return o > 0;
  endfunction

  function automatic clip_result_t clip_segment(coord_t x1, coord_t y1, coord_t x2,
      coord_t y2, coord_t x3, coord_t y3, coord_t x4, coord_t y4);
    clip_result_t r;
    logic o1;
    logic o2;
    logic signed [127:0] dx12, dy12, dx34, dy34, den, c1, c2;
    coord_t ix;
    coord_t iy;
    r = '{1'b1, x1, y1, x2, y2};
    o1 = is_outside(x3, y3, x4, y4, x1, y1);
    o2 = is_outside(x3, y3, x4, y4, x2, y2);
    if (o1 && o2) begin
      r.visible = 1'b0;
    end else if (o1 || o2) begin
      dx12 = 128'(x1) - 128'(x2);
      dy12 = 128'(y1) - 128'(y2);
      dx34 = 128'(x3) - 128'(x4);
      dy34 = 128'(y3) - 128'(y4);
      den = dx12 * dy34 - dy12 * dx34;
      ix = '0;
      iy = '0;
      if (den != 0) begin
        c1 = 128'(x1) * 128'(y2) - 128'(x2) * 128'(y1);
        c2 = 128'(x3) * 128'(y4) - 128'(x4) * 128'(y3);
        ix = quotient_sat(c1 * dx34 - dx12 * c2, den);
        iy = quotient_sat(c1 * dy34 - dy12 * c2, den);
      end
      if (o1) begin
        r.sx = ix;
        r.sy = iy;
      end else begin
        r.ex = ix;
        r.ey = iy;
      end
    end
    return r;
  endfunction

  // Holds predicted clip results in beat order and counts mismatches.
  class clip_scoreboard;
    clip_result_t pending[$];
    int errors;

    function void note_segment(coord_t f[8]);
      pending.insert(pending.size(),
                     clip_segment(f[0], f[1], f[2], f[3], f[4], f[5], f[6], f[7]));
    endfunction

    function void check_result(clip_result_t got);
      clip_result_t exp;
      if (pending.size() == 0) begin
        $display("%0t: unexpected result %p", $time, got);
        errors++;
        return;
      end
      exp = pending.pop_front();
      if (got.visible !== exp.visible) begin
        $display("%0t: visible exp %0d got %0d", $time, exp.visible, got.visible);
        errors++;
      end
      if (got.sx !== exp.sx) begin
        $display("%0t: start_x exp %0d got %0d", $time, exp.sx, got.sx);
        errors++;
      end
      if (got.sy !== exp.sy) begin
        $display("%0t: start_y exp %0d got %0d", $time, exp.sy, got.sy);
        errors++;
      end
      if (got.ex !== exp.ex) begin
        $display("%0t: end_x exp %0d got %0d", $time, exp.ex, got.ex);
        errors++;
      end
      if (got.ey !== exp.ey) begin
        $display("%0t: end_y exp %0d got %0d", $time, exp.ey, got.ey);
        errors++;
      end
    endfunction
  endclass

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  logic in_ready_o;
  coord_t seg_start_x_i = '0, seg_start_y_i = '0, seg_end_x_i = '0, seg_end_y_i = '0;
  coord_t clip_from_x_i = '0, clip_from_y_i = '0, clip_to_x_i = '0, clip_to_y_i = '0;
  logic out_valid_o;
  logic out_ready_i = 1'b0;
  logic visible_o;
  coord_t out_start_x_o, out_start_y_o, out_end_x_o, out_end_y_o;

  clip_scoreboard board = new();
  bit stall_free = 1'b0;

  segment_half_plane_clip #(.COORD_WIDTH(CW)) i_dut (.*);

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // Mostly short gaps, now and then a long one.
  function automatic int gap_len();
    if ($urandom_range(0, 19) == 0) return $urandom_range(10, 40);
    if ($urandom_range(0, 1) == 0) return 0;
    return $urandom_range(1, 3);
  endfunction

  function automatic coord_t edge_coord();
    case ($urandom_range(0, 5))
      0: return {1'b0, {(CW-1){1'b1}}};
      1: return {1'b1, {(CW-1){1'b0}}};
      2: return '0;
      3: return coord_t'(coord_t'($urandom_range(0, 64)) - 32);
      default: return coord_t'($urandom);
    endcase
  endfunction

  // Presents one beat and holds it until the block takes it. Valid stays
  // high into the next beat when no gap follows.
  task automatic send_segment(coord_t f[8]);
    int gap;
    gap = gap_len();
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    {seg_start_x_i, seg_start_y_i, seg_end_x_i, seg_end_y_i} <= {f[0], f[1], f[2], f[3]};
    {clip_from_x_i, clip_from_y_i, clip_to_x_i, clip_to_y_i} <= {f[4], f[5], f[6], f[7]};
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    board.note_segment(f);
  endtask

  task automatic send_mixed(int n);
    coord_t f[8];
    for (int i = 0; i < n; i++) begin
      for (int k = 0; k < 8; k++) f[k] = edge_coord();
      // Often a short clip line, with its end near its start.
      if ($urandom_range(0, 2) != 0) begin
        f[6] = coord_t'(f[4] + coord_t'($urandom_range(0, 200)) - 100);
        f[7] = coord_t'(f[5] + coord_t'($urandom_range(0, 200)) - 100);
      end
      send_segment(f);
    end
  endtask

  // Output side: random stalls, checked at the accepting edge.
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i)
      board.check_result('{visible_o, out_start_x_o, out_start_y_o, out_end_x_o, out_end_y_o});
  end

  initial begin
    int hold;
    hold = 0;
    forever begin
      @(posedge clk_i);
      if (stall_free || hold == 0) begin
        out_ready_i <= 1'b1;
        if (!stall_free && $urandom_range(0, 3) == 0) hold = gap_len() + 1;
      end else begin
        out_ready_i <= 1'b0;
        hold--;
      end
    end
  end

  initial begin
    coord_t f[8];
    coord_t mx, mn;
    mx = {1'b0, {(CW-1){1'b1}}};
    mn = {1'b1, {(CW-1){1'b0}}};
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    // Directed: inside, rejected, each endpoint clipped, on-line, degenerate, extremes.
    f = '{0, 0, 16, 16, 0, 100, 0, -100};   send_segment(f);
    f = '{-16, 0, -32, 16, 0, 100, 0, -100}; send_segment(f);
    f = '{16, 0, 32, 16, 0, 100, 0, -100};  send_segment(f);
    f = '{-16, 5, 40, 9, 0, -100, 0, 100};  send_segment(f);
    f = '{40, 5, -16, 9, 0, -100, 0, 100};  send_segment(f);
    f = '{0, 5, 40, 9, 0, -100, 0, 100};    send_segment(f);
    f = '{7, 3, 9, 4, 5, 5, 5, 5};          send_segment(f);
    f = '{10, 0, 10, 0, 0, -100, 0, 100};   send_segment(f);
    f = '{-10, 0, 10, 0, 0, -100, 0, 100};  send_segment(f);
    f = '{mn, mn, mx, mx, mx, mn, mn, mx};  send_segment(f);
    f = '{mx, mx, mn, mn, mn, mx, mx, mn};  send_segment(f);
    f = '{mx, mn, mn, mx, mn, mn, mx, mx};  send_segment(f);
    f = '{mn, 0, mx, 1, 0, mn, 1, mx};      send_segment(f);
    f = '{mx, mx, mx, mx, mx, mx, mx, mx};  send_segment(f);
    f = '{mn, mn, mn, mn, mn, mn, mn, mn};  send_segment(f);
    f = '{-1, 0, 1, 1, 0, 1, 1, 0};         send_segment(f);
    // Sender waits until the pipe has fully drained.
    in_valid_i <= 1'b0;
    while (board.pending.size() != 0) @(posedge clk_i);
    send_mixed(270);
    in_valid_i <= 1'b0;
    while (board.pending.size() != 0) @(posedge clk_i);
    send_mixed(270);
    in_valid_i <= 1'b0;
    stall_free = 1'b1;
    while (board.pending.size() != 0) @(posedge clk_i);
    repeat (PipeLatency + 10) @(posedge clk_i);
    if (board.errors == 0 && board.pending.size() == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

  initial begin
    #400000;
    $display("DONE: errors detected");
    $finish;
  end
endmodule
